>>> sv/shdh_pkg.sv
package shdh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_t [8];
  typedef word_t blk_t [16];

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic load;
    logic shift;
  } sched_ctrl_t;

  localparam int unsigned HDR_WORDS = 19;
  localparam int unsigned IDX_W     = 5;

  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam word_t LEN_HDR  = 32'h0000_0280;
  localparam word_t LEN_DIG  = 32'h0000_0100;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  // Which of the three compressions is running.
  localparam logic [1:0] BLK_HDR0 = 2'd0;
  localparam logic [1:0] BLK_HDR1 = 2'd1;
  localparam logic [1:0] BLK_DIG  = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_HASH = 1'b1;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap(word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic word_t round_k(logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

>>> sv/shdh_in_if.sv
interface shdh_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  word_index;
  logic [31:0] word_value;
  logic [31:0] nonce;

  modport source (output valid, func, word_index, word_value, nonce, input ready);
  modport sink   (input valid, func, word_index, word_value, nonce, output ready);
endinterface

>>> sv/shdh_out_if.sv
interface shdh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_word_0;
  logic [31:0] hash_word_1;
  logic [31:0] hash_word_2;
  logic [31:0] hash_word_3;
  logic [31:0] hash_word_4;
  logic [31:0] hash_word_5;
  logic [31:0] hash_word_6;
  logic [31:0] hash_word_7;

  modport source (output valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                  hash_word_4, hash_word_5, hash_word_6, hash_word_7, input ready);
  modport sink   (input valid, hash_word_0, hash_word_1, hash_word_2, hash_word_3,
                  hash_word_4, hash_word_5, hash_word_6, hash_word_7, output ready);
endinterface

>>> sv/shdh_sched.sv
module shdh_sched (
  input  logic                  clk_i,
  input  shdh_pkg::sched_ctrl_t ctrl_i,
  input  shdh_pkg::blk_t        blk_i,
  output shdh_pkg::word_t       w_o
);

  shdh_pkg::blk_t  win_q;
  shdh_pkg::word_t s0;
  shdh_pkg::word_t s1;
  shdh_pkg::word_t w_new;

  // The window slides by one word per round; the word sixteen ahead is formed
  // from the current contents, so the same adder serves every round.
  always_comb begin
    s0 = shdh_pkg::rotr(win_q[1], 7) ^ shdh_pkg::rotr(win_q[1], 18) ^ (win_q[1] >> 3);
    s1 = shdh_pkg::rotr(win_q[14], 17) ^ shdh_pkg::rotr(win_q[14], 19) ^ (win_q[14] >> 10);
    w_new = s1 + win_q[9] + s0 + win_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      win_q <= blk_i;
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_new;
    end
  end

  assign w_o = win_q[0];

endmodule

>>> sv/shdh_round.sv
module shdh_round (
  input  shdh_pkg::hash_t work_i,
  input  shdh_pkg::word_t k_i,
  input  shdh_pkg::word_t w_i,
  output shdh_pkg::hash_t work_o
);

  shdh_pkg::word_t big_s0;
  shdh_pkg::word_t big_s1;
  shdh_pkg::word_t ch;
  shdh_pkg::word_t mj;
  shdh_pkg::word_t t0;
  shdh_pkg::word_t t1;

  always_comb begin
    big_s1 = shdh_pkg::rotr(work_i[4], 6) ^ shdh_pkg::rotr(work_i[4], 11)
           ^ shdh_pkg::rotr(work_i[4], 25);
    ch     = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
    t0     = work_i[7] + big_s1 + ch + k_i + w_i;
    big_s0 = shdh_pkg::rotr(work_i[0], 2) ^ shdh_pkg::rotr(work_i[0], 13)
           ^ shdh_pkg::rotr(work_i[0], 22);
    mj     = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^ (work_i[1] & work_i[2]);
    t1     = big_s0 + mj;

    work_o[0] = t0 + t1;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t0;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];
  end

endmodule

>>> sv/sha256d_header_hash_top.sv
// A load item is accepted while idle and causes no result.
// A hash item runs three compressions of 64 rounds plus one feed-forward step
// each on a single round unit; the last feed-forward waits while a previous result is unclaimed.
// One hash item at a time: a new item is taken only once the sequencer is back in idle.
// Reset (asynchronous, active low) returns the sequencer to idle with no result
// pending; the header word store is not cleared and must be loaded before use.
module sha256d_header_hash_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  shdh_in_if.sink           in_i,
  shdh_out_if.source        out_o
);

  logic [1:0] state_q, state_d;
  logic [1:0] blk_q, blk_d;
  logic [5:0] rnd_q, rnd_d;
  logic       out_valid_q, out_valid_d;

  shdh_pkg::word_t hdr_q [shdh_pkg::HDR_WORDS];
  shdh_pkg::word_t nonce_q;
  shdh_pkg::hash_t cv_q, cv_d;
  shdh_pkg::hash_t work_q, work_d;
  shdh_pkg::hash_t hash_q, hash_d;

  shdh_pkg::hash_t       work_next;
  shdh_pkg::hash_t       cv_sum;
  shdh_pkg::blk_t        blk_load;
  shdh_pkg::word_t       w_cur;
  shdh_pkg::sched_ctrl_t sched_ctrl;

  logic in_acc;
  logic load_acc;
  logic hash_acc;
  logic out_stall;

  assign in_i.ready = (state_q == shdh_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && (in_i.func == shdh_pkg::FUNC_LOAD);
  assign hash_acc   = in_acc && (in_i.func == shdh_pkg::FUNC_HASH);

  // The final feed-forward waits while the previous item is still unclaimed.
  assign out_stall = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i) begin
    if (load_acc && (in_i.word_index < shdh_pkg::IDX_W'(shdh_pkg::HDR_WORDS))) begin
      hdr_q[in_i.word_index] <= in_i.word_value;
    end
    if (hash_acc) begin
      nonce_q <= in_i.nonce;
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cv_sum[j] = cv_q[j] + work_q[j];
    end
  end

  // Message block for the schedule window: the header's first sixteen words on
  // a new hash item, then the tail block, then the padded first digest.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk_load[i] = '0;
    end
    if (state_q == shdh_pkg::ST_IDLE) begin
      for (int i = 0; i < 16; i++) begin
        blk_load[i] = hdr_q[i];
      end
    end else if (blk_q == shdh_pkg::BLK_HDR0) begin
      blk_load[0]  = hdr_q[16];
      blk_load[1]  = hdr_q[17];
      blk_load[2]  = hdr_q[18];
      blk_load[3]  = nonce_q;
      blk_load[4]  = shdh_pkg::PAD_WORD;
      blk_load[15] = shdh_pkg::LEN_HDR;
    end else begin
      for (int i = 0; i < 8; i++) begin
        blk_load[i] = cv_sum[i];
      end
      blk_load[8]  = shdh_pkg::PAD_WORD;
      blk_load[15] = shdh_pkg::LEN_DIG;
    end
  end

  shdh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .blk_i  (blk_load),
    .w_o    (w_cur)
  );

  shdh_round u_round (
    .work_i (work_q),
    .k_i    (shdh_pkg::round_k(rnd_q)),
    .w_i    (w_cur),
    .work_o (work_next)
  );

  always_comb begin
    state_d          = state_q;
    blk_d            = blk_q;
    rnd_d            = rnd_q;
    out_valid_d      = out_valid_q && !out_o.ready;
    cv_d             = cv_q;
    work_d           = work_q;
    hash_d           = hash_q;
    sched_ctrl.load  = 1'b0;
    sched_ctrl.shift = 1'b0;

    case (state_q)
      shdh_pkg::ST_IDLE: begin
        if (hash_acc) begin
          cv_d            = shdh_pkg::IV;
          work_d          = shdh_pkg::IV;
          blk_d           = shdh_pkg::BLK_HDR0;
          rnd_d           = '0;
          sched_ctrl.load = 1'b1;
          state_d         = shdh_pkg::ST_ROUND;
        end
      end
      shdh_pkg::ST_ROUND: begin
        work_d           = work_next;
        sched_ctrl.shift = 1'b1;
        rnd_d            = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = shdh_pkg::ST_FINAL;
        end
      end
      shdh_pkg::ST_FINAL: begin
        if (blk_q == shdh_pkg::BLK_HDR0) begin
          cv_d            = cv_sum;
          work_d          = cv_sum;
          blk_d           = shdh_pkg::BLK_HDR1;
          sched_ctrl.load = 1'b1;
          state_d         = shdh_pkg::ST_ROUND;
        end else if (blk_q == shdh_pkg::BLK_HDR1) begin
          cv_d            = shdh_pkg::IV;
          work_d          = shdh_pkg::IV;
          blk_d           = shdh_pkg::BLK_DIG;
          sched_ctrl.load = 1'b1;
          state_d         = shdh_pkg::ST_ROUND;
        end else if (!out_stall) begin
          cv_d = cv_sum;
          for (int j = 0; j < 8; j++) begin
            hash_d[j] = shdh_pkg::bswap(cv_sum[j]);
          end
          out_valid_d = 1'b1;
          blk_d       = shdh_pkg::BLK_HDR0;
          state_d     = shdh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = shdh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shdh_pkg::ST_IDLE;
      blk_q       <= shdh_pkg::BLK_HDR0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_q       <= blk_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cv_q   <= cv_d;
    work_q <= work_d;
    hash_q <= hash_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.hash_word_0 = hash_q[0];
  assign out_o.hash_word_1 = hash_q[1];
  assign out_o.hash_word_2 = hash_q[2];
  assign out_o.hash_word_3 = hash_q[3];
  assign out_o.hash_word_4 = hash_q[4];
  assign out_o.hash_word_5 = hash_q[5];
  assign out_o.hash_word_6 = hash_q[6];
  assign out_o.hash_word_7 = hash_q[7];

  a_round_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != shdh_pkg::ST_ROUND) |-> (rnd_q == 6'd0))
    else $error("round counter not at zero outside the round loop");

  a_blk_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_q == shdh_pkg::BLK_HDR0) || (blk_q == shdh_pkg::BLK_HDR1)
    || (blk_q == shdh_pkg::BLK_DIG))
    else $error("block counter out of range");

  a_result_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == shdh_pkg::ST_FINAL)
    && ($past(blk_q) == shdh_pkg::BLK_DIG))
    else $error("result raised outside the last feed-forward");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (state_q == shdh_pkg::ST_IDLE))
    else $error("sequencer busy after delivering a result");

endmodule
